// ===== hw/rtl/rpb_pkg.sv =====
// Shared constants, codes and command/status types for the projection accumulator.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package rpb_pkg;

  localparam int DIMENSIONS = 16;
  localparam int LANES      = 4;
  localparam int LANE_W     = $clog2(LANES);
  localparam int ROWS       = (DIMENSIONS + LANES - 1) / LANES;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROWC_W     = $clog2(ROWS + 1);

  localparam logic [34:0] LCG_MUL  = 35'h5DEECE66D;
  localparam logic [23:0] MUL_LO   = LCG_MUL[23:0];
  localparam logic [10:0] MUL_HI   = LCG_MUL[34:24];
  localparam logic [47:0] LCG_ADD  = 48'hB;
  localparam logic [15:0] SEED_LOW = 16'h330E;

  localparam logic [1:0] OP_ACCUMULATE = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_CLEAR      = 2'd2;

  typedef struct packed {
    logic             load_acc;
    logic             clear;
    logic             rd_en;
    logic             rd_dim;
    logic             x_step;
    logic             wr_en;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;
    logic             out_load;
  } rpb_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } rpb_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rpb_if.sv =====
// Valid/ready channel interfaces for requests and results.
// No dependencies beyond the package order.
`timescale 1ns / 1ps
`default_nettype none

interface rpb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] block_address;
  logic [31:0] instr_count;
  logic [3:0]  dim_index;

  modport source (output valid, output op, output block_address, output instr_count,
                  output dim_index, input ready);
  modport sink (input valid, input op, input block_address, input instr_count,
                input dim_index, output ready);
endinterface

interface rpb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] dimension_value;
  logic [63:0] instruction_total;

  modport source (output valid, output dimension_value, output instruction_total,
                  input ready);
  modport sink (input valid, input dimension_value, input instruction_total,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rpb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
`timescale 1ns / 1ps
`default_nettype none

module rpb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rpb_ctrl.sv =====
// Sequencer: walks accumulate requests row by row and schedules reads and clears.
// Depends on rpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  input  rpb_pkg::rpb_sts_t sts,
  output rpb_pkg::rpb_cmd_t cmd
);
  import rpb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  localparam logic [1:0] S_RD   = 2'd3;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  logic [ROWC_W-1:0] row_r;
  logic [ROWC_W-1:0] row_nxt;
  logic [ROWC_W-1:0] row_m1;
  logic              in_fire;
  logic              last_row;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign row_m1   = row_r - ROWC_W'(1);
  assign last_row = (row_r == ROWC_W'(ROWS));

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    cmd        = '0;
    cmd.rd_row = row_r[ROW_W-1:0];
    cmd.wr_row = row_m1[ROW_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_ACCUMULATE: begin
              cmd.load_acc = 1'b1;
              row_nxt      = '0;
              state_nxt    = S_MUL;
            end
            OP_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_dim = 1'b1;
              state_nxt  = S_RD;
            end
            OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.x_step = 1'b1;
        cmd.wr_en  = (row_r != '0);
        cmd.rd_en  = !last_row;
        if (last_row) begin
          state_nxt = S_IDLE;
        end else begin
          row_nxt   = row_r + ROWC_W'(1);
          state_nxt = S_MUL;
        end
      end
      S_RD: begin
        if (!sts.out_blocked) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

  a_acc_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_ACCUMULATE) |=> (state_r == S_MUL && row_r == '0))
    else $error("accumulate did not start at row zero");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && last_row) |=> (state_r == S_IDLE))
    else $error("sequencer ran past the last row");

  a_rw_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && cmd.rd_en) |-> (cmd.wr_row != cmd.rd_row))
    else $error("read and write hit the same row");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (state_r == S_RD && !sts.out_blocked))
    else $error("result loaded over a waiting result");

endmodule

`default_nettype wire

// ===== hw/rtl/rpb_datapath.sv =====
// Datapath: four generator lanes, weight multipliers, lane-banked sum RAMs, total and
// result register. Depends on rpb_pkg and rpb_ram.
`timescale 1ns / 1ps
`default_nettype none

module rpb_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  rpb_pkg::rpb_cmd_t cmd,
  output rpb_pkg::rpb_sts_t sts,
  input  logic [63:0]       in_block_address,
  input  logic [31:0]       in_instr_count,
  input  logic [3:0]        in_dim_index,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [63:0]       out_dimension_value,
  output logic [63:0]       out_instruction_total
);
  import rpb_pkg::*;

  logic [47:0]       x_r    [LANES];
  logic [47:0]       pp0_r  [LANES];
  logic [23:0]       pp1_r  [LANES];
  logic [23:0]       pp2_r  [LANES];
  logic [47:0]       prod_r [LANES];
  logic [63:0]       rdata  [LANES];
  logic [LANES-1:0]  lane_we;
  logic [31:0]       cnt_r;
  logic [63:0]       total_r;
  logic [ROWS-1:0]   row_vld_r;
  logic              rd_vld_r;
  logic [LANE_W-1:0] rd_lane_r;
  logic              rd_inrange_r;
  logic [ROW_W-1:0]  rd_row;
  logic              out_val_r;
  logic [63:0]       dim_val_r;
  logic [63:0]       out_total_r;

  assign rd_row = cmd.rd_dim ? ROW_W'(in_dim_index >> LANE_W) : cmd.rd_row;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [47:0] seed;
    logic [63:0] wsum;

    assign seed = {in_block_address[31:0] + 32'(k), SEED_LOW};
    assign wsum = (rd_vld_r ? rdata[k] : 64'd0) + 64'(prod_r[k]);
    assign lane_we[k] = cmd.wr_en &&
      ({1'b0, cmd.wr_row, LANE_W'(k)} < (ROW_W + LANE_W + 1)'(DIMENSIONS));

    always_ff @(posedge clk) begin
      if (cmd.load_acc) begin
        x_r[k] <= seed;
      end else if (cmd.x_step) begin
        x_r[k] <= pp0_r[k] + {pp1_r[k] + pp2_r[k], 24'd0} + LCG_ADD;
      end
      pp0_r[k]  <= 48'(x_r[k][23:0]) * 48'(MUL_LO);
      pp1_r[k]  <= 24'(x_r[k][23:0] * {13'd0, MUL_HI});
      pp2_r[k]  <= 24'(x_r[k][47:24] * MUL_LO);
      prod_r[k] <= 48'(x_r[k][31:16]) * 48'(cnt_r);
    end

    rpb_ram #(
      .WIDTH(64),
      .DEPTH(ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (lane_we[k]),
      .waddr (cmd.wr_row),
      .wdata (wsum),
      .re    (cmd.rd_en),
      .raddr (rd_row),
      .rdata (rdata[k])
    );
  end

  always_ff @(posedge clk) begin
    if (cmd.load_acc) begin
      cnt_r <= in_instr_count;
    end
    if (cmd.rd_en) begin
      rd_vld_r <= (32'(rd_row) < ROWS) ? row_vld_r[rd_row] : 1'b0;
    end
    if (cmd.rd_dim) begin
      rd_lane_r    <= in_dim_index[LANE_W-1:0];
      rd_inrange_r <= (32'(in_dim_index) < DIMENSIONS);
    end
    if (cmd.out_load) begin
      dim_val_r   <= (rd_inrange_r && rd_vld_r) ? rdata[rd_lane_r] : 64'd0;
      out_total_r <= total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      row_vld_r <= '0;
      out_val_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        total_r   <= '0;
        row_vld_r <= '0;
      end else begin
        if (cmd.load_acc) begin
          total_r <= total_r + 64'(in_instr_count);
        end
        if (cmd.wr_en) begin
          row_vld_r[cmd.wr_row] <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_val_r <= 1'b1;
      end else if (out_ready) begin
        out_val_r <= 1'b0;
      end
    end
  end

  assign sts.out_blocked      = out_val_r && !out_ready;
  assign out_valid             = out_val_r;
  assign out_dimension_value   = dim_val_r;
  assign out_instruction_total = out_total_r;

endmodule

`default_nettype wire

// ===== hw/rtl/random_projection_bbv_accumulator.sv =====
// Top level of the basic block vector random projection accumulator.
// Depends on rpb_pkg, rpb_if, rpb_ram, rpb_ctrl and rpb_datapath.
//
// Keeps a 64-bit instruction total and DIMENSIONS 64-bit projection sums, held in
// four RAM banks (one per generator lane) of DIMENSIONS/4 rows, rounded up. An
// accumulate request is accepted in S_IDLE and then walks each row through S_MUL
// and S_ADD, since each 48-bit generator step forms partial products and then sums
// them; a final S_MUL and S_ADD pass adds the last row's weights. A read request is
// accepted and then waits in S_RD for the result register to empty; clear and the
// unused opcode finish in the accept cycle. Sums reset and clear through per-row
// valid bits, so no clearing pass is needed. New requests are taken while a read result waits.
`timescale 1ns / 1ps
`default_nettype none

module random_projection_bbv_accumulator (
  input  logic            clk,
  input  logic            rst_n,
  rpb_in_if.sink          in_ch,
  rpb_out_if.source       out_ch
);
  import rpb_pkg::*;

  rpb_cmd_t cmd;
  rpb_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  rpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpb_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_block_address      (in_ch.block_address),
    .in_instr_count        (in_ch.instr_count),
    .in_dim_index          (in_ch.dim_index),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_dimension_value   (out_ch.dimension_value),
    .out_instruction_total (out_ch.instruction_total)
  );

endmodule

`default_nettype wire
